FILE: hdl/ftpp_pkg.sv
`default_nettype none
package ftpp_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CTRL_START = 8'd1;
  localparam logic [7:0] CTRL_DATA  = 8'd2;
  localparam logic [7:0] CTRL_END   = 8'd3;
  localparam logic [7:0] TLV_SIZE   = 8'd0;
  localparam logic [7:0] TLV_NAME   = 8'd1;

  localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
  localparam logic [2:0] KIND_FILENAME  = 3'd1;
  localparam logic [2:0] KIND_START     = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_DATA      = 3'd4;
  localparam logic [2:0] KIND_MALFORMED = 3'd5;

  typedef enum logic [3:0] {
    PH_CTRL    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_LEN     = 4'd2,
    PH_VAL     = 4'd3,
    PH_SEQ     = 4'd4,
    PH_LHI     = 4'd5,
    PH_LLO     = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_TRAIL   = 4'd8,
    PH_SKIP    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] size_value;
    logic [7:0]  sequence_res;
    logic [15:0] data_length;
    logic        last;
  } out_item_t;

  // What one input byte asks the back end to emit: an optional passed-out
  // byte, then an optional closing result.
  typedef struct packed {
    logic        has_byte;
    logic [2:0]  byte_kind;
    logic [7:0]  byte_val;
    logic        has_close;
    logic [2:0]  close_kind;
    logic [31:0] size_value;
    logic [7:0]  seq;
    logic [15:0] length;
  } action_t;

endpackage
`default_nettype wire

FILE: hdl/file_transfer_packet_parser.sv
// File-transfer packet parser.
// Input channel (in_valid/in_ready/in_item): one packet byte per item, with
// end_of_packet set on the last byte. Output channel (out_valid/out_ready/
// out_item): passed-out payload or filename bytes and one closing result per
// packet (start/end/data done or malformed); last marks the final result
// caused by an input byte.
// Front end: the packet state machine; takes one byte per cycle while the queue
// has room and turns it into an action record (up to one byte result plus one
// closing result). Header bytes produce no record unless they end the packet.
// Queue: four records between front and back, so each side stalls alone.
// Back end: drains records into a registered output, one result per cycle while the receiver is ready.
// A result passes through the queue and then the registered output. Throughput:
// one byte per cycle while the queue has room; a byte that yields two
// results (payload or filename byte on the last byte) sends them one after
// the other through the single output register.
// Reset (rst, synchronous): parser back to expecting a control byte, the
// retained file size cleared, queue and output emptied.
// Receiver stall: the output register holds; the queue fills, then in_ready
// drops until space frees up.
`default_nettype none
module file_transfer_packet_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ftpp_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ftpp_pkg::out_item_t       out_item
);
  import ftpp_pkg::*;

  logic    q_full, q_push, q_pop, q_head_valid;
  action_t q_push_data, q_head;

  ftpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  ftpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ftpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

FILE: hdl/ftpp_front.sv
`default_nettype none
module ftpp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ftpp_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output ftpp_pkg::action_t      q_data
);
  import ftpp_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  packet_class, packet_class_next;
  logic [7:0]  field_type, field_type_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] size_accum, size_accum_next;
  logic [2:0]  size_bytes_seen, size_bytes_seen_next;
  logic [7:0]  seq_held, seq_held_next;
  logic [15:0] length_held, length_held_next;
  logic        accept;
  logic [7:0]  b;
  action_t     act;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_item.byte_value;

  always_comb begin
    phase_next           = phase;
    packet_class_next    = packet_class;
    field_type_next      = field_type;
    bytes_left_next      = bytes_left;
    size_accum_next      = size_accum;
    size_bytes_seen_next = size_bytes_seen;
    seq_held_next        = seq_held;
    length_held_next     = length_held;
    act                  = '0;

    case (phase)
      PH_CTRL: begin
        if (b == CTRL_START || b == CTRL_END) begin
          packet_class_next = b[1:0];
          phase_next        = PH_TYPE;
        end else if (b == CTRL_DATA) begin
          packet_class_next = b[1:0];
          phase_next        = PH_SEQ;
        end else begin
          packet_class_next = 2'd0;
          phase_next        = PH_SKIP;
        end
      end
      PH_TYPE: begin
        field_type_next = b;
        phase_next      = PH_LEN;
      end
      PH_LEN: begin
        bytes_left_next = {8'd0, b};
        if (field_type == TLV_SIZE) begin
          size_accum_next      = '0;
          size_bytes_seen_next = '0;
        end
        phase_next = (b != 8'd0) ? PH_VAL : PH_TYPE;
      end
      PH_VAL: begin
        if (field_type == TLV_NAME) begin
          act.has_byte  = 1'b1;
          act.byte_kind = KIND_FILENAME;
          act.byte_val  = b;
        end else if (field_type == TLV_SIZE && size_bytes_seen < 3'd4) begin
          size_accum_next      = {size_accum[23:0], b};
          size_bytes_seen_next = size_bytes_seen + 3'd1;
        end
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left_next == 16'd0) phase_next = PH_TYPE;
      end
      PH_SEQ: begin
        seq_held_next = b;
        phase_next    = PH_LHI;
      end
      PH_LHI: begin
        length_held_next = {b, 8'd0};
        phase_next       = PH_LLO;
      end
      PH_LLO: begin
        length_held_next = {length_held[15:8], b};
        bytes_left_next  = length_held_next;
        phase_next       = (length_held_next != 16'd0) ? PH_PAYLOAD : PH_TRAIL;
      end
      PH_PAYLOAD: begin
        act.has_byte    = 1'b1;
        act.byte_kind   = KIND_PAYLOAD;
        act.byte_val    = b;
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left_next == 16'd0) phase_next = PH_TRAIL;
      end
      default: begin
      end
    endcase

    if (in_item.end_of_packet) begin
      act.has_close = 1'b1;
      if ((packet_class_next == CTRL_START[1:0] ||
           packet_class_next == CTRL_END[1:0]) && phase_next == PH_TYPE) begin
        act.close_kind = (packet_class_next == CTRL_START[1:0]) ? KIND_START
                                                                : KIND_END;
        act.size_value = size_accum_next;
      end else if (packet_class_next == CTRL_DATA[1:0] && phase_next == PH_TRAIL) begin
        act.close_kind = KIND_DATA;
        act.seq        = seq_held_next;
        act.length     = length_held_next;
      end else begin
        act.close_kind = KIND_MALFORMED;
      end
      phase_next = PH_CTRL;
    end
  end

  assign q_push = accept && (act.has_byte || act.has_close);
  assign q_data = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CTRL;
      packet_class    <= '0;
      field_type      <= '0;
      bytes_left      <= '0;
      size_accum      <= '0;
      size_bytes_seen <= '0;
      seq_held        <= '0;
      length_held     <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      packet_class    <= packet_class_next;
      field_type      <= field_type_next;
      bytes_left      <= bytes_left_next;
      size_accum      <= size_accum_next;
      size_bytes_seen <= size_bytes_seen_next;
      seq_held        <= seq_held_next;
      length_held     <= length_held_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ftpp_queue.sv
`default_nettype none
module ftpp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ftpp_pkg::action_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output ftpp_pkg::action_t      head
);
  import ftpp_pkg::*;

  action_t               entries [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr, rd_ptr;
  logic [QueueCntW-1:0]  count;
  logic                  do_push, do_pop;

  assign full       = (count == QueueCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ftpp_back.sv
`default_nettype none
module ftpp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire ftpp_pkg::action_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ftpp_pkg::out_item_t    out_item
);
  import ftpp_pkg::*;

  logic      byte_done;   // passed-out byte of head entry already sent
  logic      load;
  logic      send_byte;
  out_item_t res;

  assign load      = head_valid && (!out_valid || out_ready);
  assign send_byte = head.has_byte && !byte_done;
  assign pop       = load && !(send_byte && head.has_close);

  always_comb begin
    res = '0;
    if (send_byte) begin
      res.kind     = head.byte_kind;
      res.out_byte = head.byte_val;
      res.last     = !head.has_close;
    end else begin
      res.kind         = head.close_kind;
      res.size_value   = head.size_value;
      res.sequence_res = head.seq;
      res.data_length  = head.length;
      res.last         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_done <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) byte_done <= send_byte && head.has_close;
    end
  end

endmodule
`default_nettype wire

FILE: tb/ftpp_result_checker.sv
`timescale 1ns / 100ps
module ftpp_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ftpp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ftpp_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);
  import ftpp_pkg::*;

  // shadow copy of the parser state
  phase_t      phase;
  logic [7:0]  packet_class;
  logic [7:0]  field_type;
  logic [15:0] bytes_left;
  logic [31:0] size_accum;
  logic [2:0]  size_seen;
  logic [7:0]  seq_held;
  logic [15:0] length_held;

  out_item_t   predicted_results[$];
  out_item_t   want;
  int          errors = 0;

  function automatic out_item_t make_result(input logic [2:0] kind, input logic [7:0] b,
                                            input logic [31:0] fs, input logic [7:0] sq,
                                            input logic [15:0] len);
    out_item_t r;
    r.kind         = kind;
    r.out_byte     = b;
    r.size_value   = fs;
    r.sequence_res = sq;
    r.data_length  = len;
    r.last         = 1'b0;
    return r;
  endfunction

  // Advance the shadow parser by one byte and queue the results it causes.
  function automatic void parse_byte(input in_item_t it);
    out_item_t  res[2];
    int         n;
    logic [7:0] b;
    n = 0;
    b = it.byte_value;
    case (phase)
      PH_CTRL: begin
        if (b == CTRL_START || b == CTRL_END) begin
          packet_class = b;
          phase        = PH_TYPE;
        end else if (b == CTRL_DATA) begin
          packet_class = b;
          phase        = PH_SEQ;
        end else begin
          packet_class = 8'd0;
          phase        = PH_SKIP;
        end
      end
      PH_TYPE: begin
        field_type = b;
        phase      = PH_LEN;
      end
      PH_LEN: begin
        bytes_left = {8'd0, b};
        if (field_type == TLV_SIZE) begin
          size_accum = '0;
          size_seen  = '0;
        end
        phase = (b != 8'd0) ? PH_VAL : PH_TYPE;
      end
      PH_VAL: begin
        if (field_type == TLV_NAME) begin
          res[n] = make_result(KIND_FILENAME, b, '0, '0, '0);
          n++;
        end else if (field_type == TLV_SIZE && size_seen < 3'd4) begin
          size_accum = {size_accum[23:0], b};
          size_seen++;
        end
        bytes_left--;
        if (bytes_left == 16'd0) phase = PH_TYPE;
      end
      PH_SEQ: begin
        seq_held = b;
        phase    = PH_LHI;
      end
      PH_LHI: begin
        length_held = {b, 8'd0};
        phase       = PH_LLO;
      end
      PH_LLO: begin
        length_held[7:0] = b;
        bytes_left       = {length_held[15:8], b};
        phase            = (bytes_left != 16'd0) ? PH_PAYLOAD : PH_TRAIL;
      end
      PH_PAYLOAD: begin
        res[n] = make_result(KIND_PAYLOAD, b, '0, '0, '0);
        n++;
        bytes_left--;
        if (bytes_left == 16'd0) phase = PH_TRAIL;
      end
      default: ;
    endcase

    if (it.end_of_packet) begin
      if ((packet_class == CTRL_START || packet_class == CTRL_END) && phase == PH_TYPE)
        res[n] = make_result((packet_class == CTRL_START) ? KIND_START : KIND_END,
                             '0, size_accum, '0, '0);
      else if (packet_class == CTRL_DATA && phase == PH_TRAIL)
        res[n] = make_result(KIND_DATA, '0, '0, seq_held, length_held);
      else
        res[n] = make_result(KIND_MALFORMED, '0, '0, '0, '0);
      n++;
      phase = PH_CTRL;
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) predicted_results.push_back(res[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase        = PH_CTRL;
      packet_class = '0;
      field_type   = '0;
      bytes_left   = '0;
      size_accum   = '0;
      size_seen    = '0;
      seq_held     = '0;
      length_held  = '0;
      predicted_results.delete();
    end else begin
      // results leave before new bytes are predicted; no result leaves in the cycle its byte is accepted
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display(
              "%0t: unexpected kind=%0d byte=%02h size=%08h seq=%02h len=%04h last=%0d",
              $realtime, out_item.kind, out_item.out_byte, out_item.size_value,
              out_item.sequence_res, out_item.data_length, out_item.last);
        end else begin
          want = predicted_results.pop_front();
          if (out_item.kind !== want.kind || out_item.out_byte !== want.out_byte ||
              out_item.size_value !== want.size_value ||
              out_item.sequence_res !== want.sequence_res ||
              out_item.data_length !== want.data_length || out_item.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display(
                "%0t: expected kind=%0d byte=%02h size=%08h seq=%02h len=%04h last=%0d",
                $realtime, want.kind, want.out_byte, want.size_value,
                want.sequence_res, want.data_length, want.last);
              $display(
                "%0t: actual   kind=%0d byte=%02h size=%08h seq=%02h len=%04h last=%0d",
                $realtime, out_item.kind, out_item.out_byte, out_item.size_value,
                out_item.sequence_res, out_item.data_length, out_item.last);
            end
          end
        end
      end
      if (in_valid && in_ready) parse_byte(in_item);
    end
    fail_count <= errors;
    pending    <= predicted_results.size();
  end

endmodule

FILE: tb/file_transfer_packet_parser_tb.sv
`timescale 1ns / 100ps
module file_transfer_packet_parser_tb;
  import ftpp_pkg::*;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  // bytes of the packet being assembled; eop goes on the last one
  logic [7:0] pkt_bytes[$];
  // sender burst bookkeeping
  int         burst_left = 0;
  // bytes sent in the random part
  int         random_items = 0;

  always #10 clk = ~clk;

  file_transfer_packet_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  ftpp_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one byte and hold it until accepted. At the start of each burst
  // the sender may drop valid for a random gap; inside a burst valid stays
  // high from item to item. Occasional long bursts give stretches with no
  // idling at all.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid                <= 1'b1;
    in_item.byte_value      <= b;
    in_item.end_of_packet   <= eop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send the assembled packet with eop on its final byte, then clear it.
  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  // START or END packet with 0..3 TLV fields. Size fields run 0..6 bytes so
  // short and long size fields both show up; unknown types get skipped.
  task automatic build_control_packet(input logic [7:0] ctl);
    int         nfields;
    int         sel;
    int         len;
    logic [7:0] ftype;
    pkt_bytes.push_back(ctl);
    nfields = $urandom_range(0, 3);
    for (int f = 0; f < nfields; f++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        ftype = TLV_SIZE;
        len   = $urandom_range(0, 6);
      end else if (sel < 8) begin
        ftype = TLV_NAME;
        len   = $urandom_range(0, 6);
      end else begin
        ftype = 8'($urandom_range(2, 255));
        len   = $urandom_range(0, 5);
      end
      pkt_bytes.push_back(ftype);
      pkt_bytes.push_back(len[7:0]);
      for (int k = 0; k < len; k++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // DATA packet: mostly short payloads, rarely one long enough to use the
  // high length byte, sometimes trailing bytes the parser must ignore.
  task automatic build_data_packet();
    int len;
    int sel;
    sel = $urandom_range(0, 39);
    if (sel == 0)     len = $urandom_range(256, 400);
    else if (sel < 6) len = 0;
    else              len = $urandom_range(1, 8);
    pkt_bytes.push_back(CTRL_DATA);
    pkt_bytes.push_back(8'($urandom_range(0, 255)));
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(len[7:0]);
    for (int k = 0; k < len; k++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Receiver: holds off at the start while the sender keeps offering, so
  // the queue fills and in_ready drops. After that it cycles through
  // segments: always ready, coin-flip, mostly ready, alternating, and now
  // and then another long hold-off.
  initial begin : receiver
    int mode;
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b0;
    repeat (60) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(20, 150);
      if (mode == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(40, 80)) @(posedge clk);
      end else begin
        for (int i = 0; i < span; i++) begin
          case (mode)
            1, 2, 3: out_ready <= 1'b1;
            4, 5:    out_ready <= 1'($urandom_range(0, 1));
            6, 7:    out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= i[0];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int pick;
    int cut;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed packets.
    // START: five-byte size field (fifth byte dropped, all ones), then a
    // one-byte filename whose byte lands on the last byte of the packet.
    pkt_bytes = '{CTRL_START, TLV_SIZE, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12,
                  TLV_NAME, 8'd1, 8'h00};
    send_packet();
    // END with only the control byte: closes at once, keeps the old size.
    pkt_bytes = '{CTRL_END};
    send_packet();
    // DATA, one payload byte on the last byte: payload plus closing.
    pkt_bytes = '{CTRL_DATA, 8'hFF, 8'h00, 8'h01, 8'h80};
    send_packet();
    // DATA of length zero followed by bytes that are ignored.
    pkt_bytes = '{CTRL_DATA, 8'h00, 8'h00, 8'h00, 8'h55, 8'hAA};
    send_packet();
    // control byte zero is unknown
    pkt_bytes = '{8'h00};
    send_packet();
    // DATA cut off inside its header
    pkt_bytes = '{CTRL_DATA, 8'h07};
    send_packet();

    // Random part: mostly well-formed packets with random contents, the
    // rest truncated packets or unknown control bytes.
    while (random_items < 900) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        build_control_packet(CTRL_START);
      end else if (pick <= 4) begin
        build_control_packet(CTRL_END);
      end else if (pick <= 7) begin
        build_data_packet();
      end else if (pick == 8) begin
        // truncated: build any kind, then cut the tail off
        case ($urandom_range(0, 2))
          0:       build_control_packet(CTRL_START);
          1:       build_control_packet(CTRL_END);
          default: build_data_packet();
        endcase
        cut = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end else begin
        // unknown control byte; the rest of the packet is ignored
        pkt_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'h00
                                                        : 8'($urandom_range(4, 255)));
        repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
      random_items += pkt_bytes.size();
      send_packet();
    end
    in_valid <= 1'b0;

    // pending is registered, so it trails the accepting edge
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // room for any stray result still in flight
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: 10 ms, far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
